// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the touch point event tracker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== rtl/tpet_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpet_pkg
// Types and constants of the touch point event tracker.
// ----------------------------------------------------------------------------
package tpet_pkg;

  // Sizing
  localparam int MAX_TOUCHES = 5;
  localparam int MAX_EVENTS  = 10;
  localparam int IDX_W       = (MAX_TOUCHES > 1) ? $clog2(MAX_TOUCHES) : 1;
  localparam int CNT_W       = $clog2(MAX_TOUCHES + 1);
  localparam int SLOT_W      = 4;
  localparam int SUM_W       = SLOT_W + 1;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // Status byte layout
  localparam int STATUS_READY_BIT = 7;
  localparam int STATUS_COUNT_W   = 4;

  // Item kinds on the input channel
  localparam logic ACT_HEADER = 1'b0;
  localparam logic ACT_POINT  = 1'b1;

  // Event kinds on the result channel
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_PRESS   = 2'd1;
  localparam logic [1:0] KIND_CONTACT = 2'd2;
  localparam logic [1:0] KIND_LIFT    = 2'd3;

  typedef struct packed {
    logic        action;
    logic [7:0]  status_byte;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic [15:0] point_weight;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic [15:0] event_x;
    logic [15:0] event_y;
    logic [15:0] event_weight;
    logic [1:0]  event_kind;
    logic [3:0]  total_reported;
    logic        frame_end;
  } out_item_t;

  localparam out_item_t EMPTY_RESULT = '{
    slot: 4'd0, event_x: 16'd0, event_y: 16'd0, event_weight: 16'd0,
    event_kind: KIND_NONE, total_reported: 4'd0, frame_end: 1'b1
  };

  // Commands from the front end to the back end
  typedef enum logic [1:0] {
    CMD_EMPTY  = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic             last;
    logic [IDX_W-1:0] idx;
    logic [15:0]      x;
    logic [15:0]      y;
    logic [15:0]      w;
  } cmd_t;

endpackage

// ===== rtl/tpet_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpet_front
// Accepts headers and point records, tracks the open frame and turns each
// point of that frame, and each header with no points to follow, into a command for the back end.
// ----------------------------------------------------------------------------
module tpet_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tpet_pkg::in_item_t in_item,
  input  logic               q_full,
  output logic               q_push,
  output tpet_pkg::cmd_t     q_cmd
);
  import tpet_pkg::*;

  logic [CNT_W-1:0]          expected_r, expected_nxt;
  logic [CNT_W-1:0]          received_r, received_nxt;
  logic                      accept;
  logic [STATUS_COUNT_W-1:0] hdr_count;
  logic                      hdr_ok;
  logic                      pt_last;

  assign busy      = q_full;
  assign accept    = start && !busy;
  assign hdr_count = in_item.status_byte[STATUS_COUNT_W-1:0];
  assign hdr_ok    = in_item.status_byte[STATUS_READY_BIT] &&
                     (hdr_count <= STATUS_COUNT_W'(MAX_TOUCHES));
  assign pt_last   = ((received_r + CNT_W'(1)) == expected_r);

  // Classify the request
  always_comb begin
    expected_nxt = expected_r;
    received_nxt = received_r;
    q_push       = 1'b0;
    q_cmd.op     = CMD_EMPTY;
    q_cmd.last   = 1'b0;
    q_cmd.idx    = received_r[IDX_W-1:0];
    q_cmd.x      = in_item.point_x;
    q_cmd.y      = in_item.point_y;
    q_cmd.w      = in_item.point_weight;
    if (accept) begin
      if (in_item.action == ACT_HEADER) begin
        received_nxt = '0;
        expected_nxt = '0;
        if (!hdr_ok) begin
          q_push   = 1'b1;
          q_cmd.op = CMD_EMPTY;
        end else if (hdr_count == '0) begin
          // Ready with no points: frame closes at once
          q_push   = 1'b1;
          q_cmd.op = CMD_FINISH;
        end else begin
          expected_nxt = CNT_W'(hdr_count);
        end
      end else if (expected_r != '0 && received_r < expected_r) begin
        q_push       = 1'b1;
        q_cmd.op     = CMD_POINT;
        q_cmd.last   = pt_last;
        received_nxt = received_r + CNT_W'(1);
        if (pt_last) begin
          expected_nxt = '0;
          received_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
      received_r <= '0;
    end else begin
      expected_r <= expected_nxt;
      received_r <= received_nxt;
    end
  end

endmodule

// ===== rtl/tpet_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpet_cmd_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpet_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tpet_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output tpet_pkg::cmd_t head
);
  import tpet_pkg::*;

  cmd_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign valid = (count_r != '0);
  assign head  = entry_r[rd_ptr_r];

  // Pointer and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  `ASSERT_NEVER(a_q_overflow, clk, rst_n, push && full, "queue push while full")
  `ASSERT_NEVER(a_q_underflow, clk, rst_n, pop && !valid, "queue pop while empty")
  `ASSERT_AT(a_q_level, clk, rst_n, (push && !pop) |=> (count_r == $past(count_r) + QCNT_W'(1)), "queue level did not rise on push")

endmodule

// ===== rtl/tpet_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpet_back
// Stores points, matches the stored frame against the new one and emits
// one event per cycle, then makes the new points the record.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpet_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  tpet_pkg::cmd_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  output tpet_pkg::out_item_t out_item
);
  import tpet_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MATCH = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [15:0]       cur_x_r  [MAX_TOUCHES];
  logic [15:0]       cur_y_r  [MAX_TOUCHES];
  logic [15:0]       cur_w_r  [MAX_TOUCHES];
  logic [15:0]       prev_x_r [MAX_TOUCHES];
  logic [15:0]       prev_y_r [MAX_TOUCHES];
  logic [IDX_W-1:0]  lift_idx_r [MAX_TOUCHES];
  logic [CNT_W-1:0]  prev_cnt_r, prev_cnt_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  lift_cnt_r, lift_cnt_nxt;
  logic [MAX_TOUCHES-1:0] matched_r, matched_nxt;
  logic [SLOT_W-1:0] total_r, total_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_res_r, out_res_nxt;

  logic                   cur_wr;
  logic                   lift_wr;
  logic                   copy_en;
  logic [SLOT_W-1:0]      lift_pos;
  logic [IDX_W-1:0]       prev_rd;
  logic [MAX_TOUCHES-1:0] hit;
  logic [MAX_TOUCHES-1:0] first_hit;
  logic                   hit_seen;
  logic [SUM_W-1:0]       lift_room;
  logic [SUM_W-1:0]       ev_sum;
  logic [IDX_W-1:0]       cur_rd;
  logic                   emit_last;

  assign out_valid = out_valid_r;
  assign out_item  = out_res_r;

  // Shared read port of the stored frame
  assign lift_pos = slot_r - SLOT_W'(cnt_r);
  assign prev_rd  = (state_r == ST_EMIT) ? lift_idx_r[lift_pos[IDX_W-1:0]]
                                          : idx_r[IDX_W-1:0];
  assign cur_rd   = slot_r[IDX_W-1:0];

  // Compare one stored point with every new point
  always_comb begin
    hit_seen  = 1'b0;
    first_hit = '0;
    for (int j = 0; j < MAX_TOUCHES; j++) begin
      hit[j] = (CNT_W'(j) < cnt_r) && (prev_x_r[prev_rd] == cur_x_r[j]) &&
               (prev_y_r[prev_rd] == cur_y_r[j]);
      if (hit[j] && !hit_seen) begin
        first_hit[j] = 1'b1;
        hit_seen     = 1'b1;
      end
    end
  end

  assign lift_room = SUM_W'(cnt_r) + SUM_W'(lift_cnt_r);
  assign ev_sum    = lift_room;
  assign emit_last = (total_r == '0) || ((slot_r + SLOT_W'(1)) == total_r);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    prev_cnt_nxt  = prev_cnt_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    lift_cnt_nxt  = lift_cnt_r;
    matched_nxt   = matched_r;
    total_nxt     = total_r;
    slot_nxt      = slot_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    q_pop         = 1'b0;
    cur_wr        = 1'b0;
    lift_wr       = 1'b0;
    copy_en       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_head.op)
            CMD_EMPTY: begin
              out_valid_nxt = 1'b1;
              out_res_nxt   = EMPTY_RESULT;
            end
            CMD_POINT: begin
              cur_wr = 1'b1;
              if (q_head.last) begin
                cnt_nxt      = CNT_W'(q_head.idx) + CNT_W'(1);
                idx_nxt      = '0;
                lift_cnt_nxt = '0;
                matched_nxt  = '0;
                state_nxt    = ST_MATCH;
              end
            end
            CMD_FINISH: begin
              cnt_nxt      = '0;
              idx_nxt      = '0;
              lift_cnt_nxt = '0;
              matched_nxt  = '0;
              state_nxt    = ST_MATCH;
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_MATCH: begin
        if (idx_r == prev_cnt_r) begin
          total_nxt = (ev_sum > SUM_W'(MAX_EVENTS)) ? SLOT_W'(MAX_EVENTS)
                                                    : ev_sum[SLOT_W-1:0];
          slot_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          matched_nxt = matched_r | first_hit;
          if (!hit_seen && lift_room < SUM_W'(MAX_EVENTS)) begin
            lift_wr      = 1'b1;
            lift_cnt_nxt = lift_cnt_r + CNT_W'(1);
          end
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        if (total_r == '0) begin
          out_res_nxt = EMPTY_RESULT;
        end else if (slot_r < SLOT_W'(cnt_r)) begin
          out_res_nxt.event_x      = cur_x_r[cur_rd];
          out_res_nxt.event_y      = cur_y_r[cur_rd];
          out_res_nxt.event_weight = cur_w_r[cur_rd];
          out_res_nxt.event_kind   = matched_r[cur_rd] ? KIND_CONTACT : KIND_PRESS;
        end else begin
          out_res_nxt.event_x      = prev_x_r[prev_rd];
          out_res_nxt.event_y      = prev_y_r[prev_rd];
          out_res_nxt.event_weight = '0;
          out_res_nxt.event_kind   = KIND_LIFT;
        end
        if (total_r != '0) begin
          out_res_nxt.slot           = slot_r;
          out_res_nxt.total_reported = total_r;
          out_res_nxt.frame_end      = emit_last;
        end
        if (emit_last) begin
          copy_en      = 1'b1;
          prev_cnt_nxt = cnt_r;
          state_nxt    = ST_IDLE;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_cnt_r  <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      lift_cnt_r  <= '0;
      matched_r   <= '0;
      total_r     <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_cnt_r  <= prev_cnt_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      lift_cnt_r  <= lift_cnt_nxt;
      matched_r   <= matched_nxt;
      total_r     <= total_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Point stores and result register
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    if (cur_wr) begin
      cur_x_r[q_head.idx] <= q_head.x;
      cur_y_r[q_head.idx] <= q_head.y;
      cur_w_r[q_head.idx] <= q_head.w;
    end
    if (lift_wr) begin
      lift_idx_r[lift_cnt_r[IDX_W-1:0]] <= idx_r[IDX_W-1:0];
    end
    for (int j = 0; j < MAX_TOUCHES; j++) begin
      if (copy_en && (CNT_W'(j) < cnt_r)) begin
        prev_x_r[j] <= cur_x_r[j];
        prev_y_r[j] <= cur_y_r[j];
      end
    end
  end

  `ASSERT_AT(a_pop_idle, clk, rst_n, q_pop |-> (state_r == ST_IDLE), "command taken outside idle")
  `ASSERT_AT(a_end_slot, clk, rst_n, (out_valid_r && out_res_r.frame_end && out_res_r.event_kind != KIND_NONE) |-> ((out_res_r.slot + 4'd1) == out_res_r.total_reported), "frame end not on last slot")
  `ASSERT_AT(a_total_cap, clk, rst_n, (state_r == ST_EMIT) |-> (total_r <= SLOT_W'(MAX_EVENTS)), "event total above limit")
  `ASSERT_AT(a_emit_done, clk, rst_n, (state_r == ST_EMIT && emit_last) |=> (state_r == ST_IDLE && out_valid_r && out_res_r.frame_end), "frame did not close")

endmodule

// ===== rtl/touch_point_event_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_point_event_tracker
// Tracks touch points from frame to frame and reports press, contact and
// lift events for each completed frame.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Payload
//  input     start / busy        in_item  (header or point record)
//  result    out_valid strobe    out_item (one event per strobe)
//
//  Headers and point records are taken at one per cycle while the
//  two-entry command queue has room; busy is high while it is full.
//  Closing a frame holds the back end for a match pass (P stored
//  points, one compare each), then emits one result per cycle (1 to 10).
//  A bad or not-ready header yields its empty result in the cycle after
//  the back end reaches it. Results appear for one cycle and cannot be
//  stalled. rst_n is synchronous; point stores are not cleared.
// ----------------------------------------------------------------------------
module touch_point_event_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tpet_pkg::in_item_t  in_item,
  output logic                out_valid,
  output tpet_pkg::out_item_t out_item
);
  import tpet_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;
  cmd_t q_head;

  tpet_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  tpet_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  tpet_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
